>>> design/stok_pkg.sv
// Shared types, token kinds and keyword table for the source tokenizer.
package stok_pkg;

    localparam int FIELD_W    = 24;
    localparam int KW_CHARS   = 6;
    localparam int KW_BITS    = 8 * KW_CHARS;
    localparam int KW_COUNT   = 8;
    localparam int Q_DEPTH    = 4;
    localparam int Q_IDX_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [4:0] {
        K_IDENT     = 5'd0,
        K_NUMBER    = 5'd1,
        K_COMMENT   = 5'd2,
        K_SLASH     = 5'd3,
        K_LPAREN    = 5'd4,
        K_RPAREN    = 5'd5,
        K_STAR      = 5'd6,
        K_PLUS      = 5'd7,
        K_MINUS     = 5'd8,
        K_DOT       = 5'd9,
        K_COLON     = 5'd10,
        K_SEMI      = 5'd11,
        K_LT        = 5'd12,
        K_EQ        = 5'd13,
        K_GT        = 5'd14,
        K_LBRACE    = 5'd15,
        K_RBRACE    = 5'd16,
        K_AMP       = 5'd17,
        K_AMPAMP    = 5'd18,
        K_KW_FN     = 5'd19,
        K_KW_VOID   = 5'd20,
        K_KW_LET    = 5'd21,
        K_KW_VAR    = 5'd22,
        K_KW_IF     = 5'd23,
        K_KW_ELSE   = 5'd24,
        K_KW_WHILE  = 5'd25,
        K_KW_RETURN = 5'd26,
        K_INVALID   = 5'd27
    } kind_t;

    // Keyword text packed first character in the low byte, same order as K_KW_*.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0000_6E66,
        48'h0000_6469_6F76,
        48'h0000_0074_656C,
        48'h0000_0072_6176,
        48'h0000_0000_6669,
        48'h0000_6573_6C65,
        48'h0065_6C69_6877,
        48'h6E72_7574_6572
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [4:0]         token_kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] token_length;
        logic               is_error;
        logic               last_of_run;
    } out_t;

    // Token record between front and back; identifiers still carry their prefix.
    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               err;
        logic               last;
        logic [KW_BITS-1:0] prefix;
        logic [2:0]         name_len;
    } tok_rec_t;

    typedef struct packed {
        logic [1:0] count;
        tok_rec_t   rec1;
        tok_rec_t   rec0;
    } push_t;

endpackage

>>> design/stok_front.sv
// Front end: byte classification and lexer state machine, emits token records.
module stok_front #(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  stok_pkg::in_t   in_data,
    input  logic            room,
    output stok_pkg::push_t push
);
    import stok_pkg::*;

    localparam int PB     = POSITION_BITS;
    localparam int PFX_W  = 8 * KEYWORD_CHARS;
    localparam int EXT_W  = (PB > FIELD_W) ? PB : FIELD_W;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_AMP
    } mode_t;

    typedef struct packed {
        logic     valid;
        tok_rec_t rec;
    } close_t;

    mode_t            mode_reg, mode_next;
    logic [PB-1:0]    start_reg, start_next;
    logic [PB-1:0]    pos_reg, pos_next;
    logic [PB-1:0]    len_reg, len_next;
    logic [PFX_W-1:0] prefix_reg, prefix_next;
    logic             incl_reg;

    logic       accept;
    logic [7:0] b;
    logic       is_alpha, is_digit, is_white, used;
    close_t     cl;
    tok_rec_t   slot [2];
    logic [1:0] n;

    function automatic logic [FIELD_W-1:0] to_field(input logic [PB-1:0] v);
        logic [EXT_W-1:0] e;
        begin
            e = EXT_W'(v);
            return e[FIELD_W-1:0];
        end
    endfunction

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (&v) ? v : v + PB'(1);
    endfunction

    function automatic tok_rec_t mk_rec(input kind_t k, input logic [FIELD_W-1:0] s,
                                        input logic [FIELD_W-1:0] l, input logic e);
        tok_rec_t r;
        begin
            r          = '0;
            r.kind     = k;
            r.start    = s;
            r.length   = l;
            r.err      = e;
            return r;
        end
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        begin
            unique case (c)
                8'h2F:   k = K_SLASH;
                8'h28:   k = K_LPAREN;
                8'h29:   k = K_RPAREN;
                8'h2A:   k = K_STAR;
                8'h2B:   k = K_PLUS;
                8'h2D:   k = K_MINUS;
                8'h2E:   k = K_DOT;
                8'h3A:   k = K_COLON;
                8'h3B:   k = K_SEMI;
                8'h3C:   k = K_LT;
                8'h3D:   k = K_EQ;
                8'h3E:   k = K_GT;
                8'h7B:   k = K_LBRACE;
                8'h7D:   k = K_RBRACE;
                default: k = K_INVALID;
            endcase
            return k;
        end
    endfunction

    // Record for the pending token when a non-matching byte or end of text ends it.
    function automatic close_t close_tok(input mode_t m, input logic [PB-1:0] s,
                                         input logic [PB-1:0] l, input logic [PFX_W-1:0] p,
                                         input logic incl);
        close_t c;
        begin
            c = '0;
            unique case (m)
                MODE_IDENT:
                begin
                    c.valid        = 1'b1;
                    c.rec          = mk_rec(K_IDENT, to_field(s), to_field(l), 1'b0);
                    c.rec.prefix   = p[KW_BITS-1:0];
                    c.rec.name_len = (l > PB'(7)) ? 3'd7 : l[2:0];
                end
                MODE_INT, MODE_FRAC:
                begin
                    c.valid = 1'b1;
                    c.rec   = mk_rec(K_NUMBER, to_field(s), to_field(l), 1'b0);
                end
                MODE_SLASH:
                begin
                    c.valid = 1'b1;
                    c.rec   = mk_rec(K_SLASH, to_field(s), FIELD_W'(1), 1'b0);
                end
                MODE_AMP:
                begin
                    c.valid = 1'b1;
                    c.rec   = mk_rec(K_AMP, to_field(s), FIELD_W'(1), 1'b0);
                end
                MODE_COMMENT:
                begin
                    c.valid = incl;
                    c.rec   = mk_rec(K_COMMENT, to_field(s), to_field(l), 1'b0);
                end
                default:
                begin
                    c.valid = 1'b0;
                end
            endcase
            return c;
        end
    endfunction

    assign in_ready = room;
    assign accept   = in_valid && room;
    assign b        = in_data.text_byte;
    assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    assign is_digit = (b >= 8'h30 && b <= 8'h39);
    assign is_white = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        pos_next    = pos_reg;
        used        = 1'b0;
        n           = 2'd0;
        slot[0]     = '0;
        slot[1]     = '0;
        cl          = '0;

        unique case (mode_reg)
            MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                    begin
                        if (len_reg == PB'(i))
                        begin
                            prefix_next[8*i +: 8] = b;
                        end
                    end
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (is_digit)
                begin
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end
                else if (b == CH_DOT)
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_FRAC;
                    used      = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (is_digit)
                begin
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_COMMENT;
                    used      = 1'b1;
                end
            end
            MODE_AMP:
            begin
                if (b == CH_AMP)
                begin
                    slot[n[0]] = mk_rec(K_AMPAMP, to_field(start_reg), FIELD_W'(2), 1'b0);
                    n          = n + 2'd1;
                    mode_next  = MODE_IDLE;
                    used       = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_LF)
                begin
                    cl = close_tok(mode_reg, start_reg, len_reg, prefix_reg, incl_reg);
                    if (cl.valid)
                    begin
                        slot[n[0]] = cl.rec;
                        n          = n + 2'd1;
                    end
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = sat_inc(len_reg);
                end
                used = 1'b1;
            end
            default:
            begin
                used = 1'b0;
            end
        endcase

        if (!used)
        begin
            cl = close_tok(mode_reg, start_reg, len_reg, prefix_reg, incl_reg);
            if (cl.valid)
            begin
                slot[n[0]] = cl.rec;
                n          = n + 2'd1;
            end
            mode_next = MODE_IDLE;
            if (is_white)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_alpha || is_digit || b == CH_SLASH || b == CH_AMP)
            begin
                start_next  = pos_reg;
                len_next    = PB'(1);
                prefix_next = '0;
                if (is_alpha)
                begin
                    mode_next       = MODE_IDENT;
                    prefix_next[7:0] = b;
                end
                else if (is_digit)
                begin
                    mode_next = MODE_INT;
                end
                else if (b == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else
                begin
                    mode_next = MODE_AMP;
                end
            end
            else
            begin
                slot[n[0]] = mk_rec(single_kind(b), to_field(pos_reg), FIELD_W'(1),
                                    single_kind(b) == K_INVALID);
                n          = n + 2'd1;
            end
        end

        pos_next = sat_inc(pos_reg);

        // End of text flushes the pending token and starts over at offset zero.
        if (in_data.end_of_text)
        begin
            cl = close_tok(mode_next, start_next, len_next, prefix_next, incl_reg);
            if (cl.valid)
            begin
                slot[n[0]] = cl.rec;
                n          = n + 2'd1;
            end
            mode_next   = MODE_IDLE;
            start_next  = '0;
            pos_next    = '0;
            len_next    = '0;
            prefix_next = '0;
        end

        if (n == 2'd1)
        begin
            slot[0].last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            slot[1].last = 1'b1;
        end
    end

    assign push.count = accept ? n : 2'd0;
    assign push.rec0  = slot[0];
    assign push.rec1  = slot[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            pos_reg    <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
            incl_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                incl_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg   <= mode_next;
                start_reg  <= start_next;
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                prefix_reg <= prefix_next;
            end
        end
    end

    a_eot_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.end_of_text |=> mode_reg == MODE_IDLE && pos_reg == '0)
        else $error("lexer state not cleared after end of text");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd1 |-> push.rec0.last)
        else $error("single record of a byte not marked last");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_data.end_of_text && (&pos_reg) |=> (&pos_reg))
        else $error("byte position wrapped");

endmodule

>>> design/stok_back.sv
// Back end: token queue, keyword resolution and output register.
module stok_back (
    input  logic            clk,
    input  logic            rst_n,
    input  stok_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output stok_pkg::out_t  out_data
);
    import stok_pkg::*;

    tok_rec_t             q_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0]   head_reg, head_next;
    logic [Q_IDX_W-1:0]   tail_reg, tail_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg;
    out_t                 out_reg;
    logic                 pop;
    tok_rec_t             head_rec;
    kind_t                kind;

    assign room     = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign pop      = (count_reg != '0) && (!out_valid_reg || out_ready);
    assign head_rec = q_mem[head_reg];

    // Identifier becomes a keyword when both length and stored text match.
    always_comb
    begin
        kind = head_rec.kind;
        if (head_rec.kind == K_IDENT)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (head_rec.name_len == KW_LEN[k] && head_rec.prefix == KW_TEXT[k])
                begin
                    kind = kind_t'(5'(K_KW_FN) + 5'(k));
                end
            end
        end
    end

    always_comb
    begin
        head_next  = pop ? head_reg + Q_IDX_W'(1) : head_reg;
        tail_next  = tail_reg + Q_IDX_W'(push.count);
        count_next = count_reg + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_mem[tail_reg] <= push.rec0;
        end
        if (push.count == 2'd2)
        begin
            q_mem[tail_reg + Q_IDX_W'(1)] <= push.rec1;
        end
        if (pop)
        begin
            out_reg.token_kind   <= kind;
            out_reg.start_offset <= head_rec.start;
            out_reg.token_length <= head_rec.length;
            out_reg.is_error     <= head_rec.err;
            out_reg.last_of_run  <= head_rec.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("token queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= Q_CNT_W'(Q_DEPTH - 2))
        else $error("records pushed without room");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped token not presented");

endmodule

>>> design/source_tokenizer.sv
// Top level of the source tokenizer: byte stream in, token stream out.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready        | cfg_data: include_comments
//  in      | in_valid / in_ready          | in_data: text_byte, end_of_text
//  out     | out_valid / out_ready        | out_data: kind, start, length, error, last
//
// One byte per cycle: the lexer state machine decides each accepted byte and writes
// up to two token records into a four-entry queue; the output register drains one
// token per cycle while out_ready is high. in_ready falls while the queue holds
// more than two tokens, so bytes that give two tokens or output stalls throttle
// the input. A token goes from the queue into the output register after the
// transfer of the byte that ends it; the second token of the same byte follows it.
// Reset (rst_n, async, active low) empties the queue and restarts at offset zero.
module source_tokenizer #(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  stok_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output stok_pkg::out_t out_data
);
    import stok_pkg::*;

    push_t push;
    logic  room;

    assign cfg_ready = 1'b1;

    stok_front #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .room      (room),
        .push      (push)
    );

    stok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> verif/tb_source_tokenizer.sv
// Testbench for source_tokenizer: random byte texts, token predictor, in-order scoreboard.
`timescale 1ns / 100ps

module tb_source_tokenizer;
    import stok_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_IDENT,
        LX_INT,
        LX_FRAC,
        LX_SLASH,
        LX_COMMENT,
        LX_AMP
    } lex_mode_e;

    // Tracks the lexer state and holds the tokens still owed by the block.
    class token_tracker;
        lex_mode_e          mode;
        logic [FIELD_W-1:0] tok_start;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] tok_len;
        logic [KW_BITS-1:0] prefix;
        bit                 comments_on;
        string              kw_names[KW_COUNT];
        out_t               expected_tokens[$];
        int                 mismatches;

        function new();
            kw_names = '{"fn", "void", "let", "var", "if", "else", "while", "return"};
            comments_on = 1'b0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode = LX_IDLE;
            tok_start = '0;
            position = '0;
            tok_len = '0;
            prefix = '0;
        endfunction

        function logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
            return (v == '1) ? v : v + FIELD_W'(1);
        endfunction

        function bit is_alpha(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_white(logic [7:0] b);
            return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
        endfunction

        function kind_t single_kind(logic [7:0] b);
            case (b)
                CH_SLASH: return K_SLASH;
                "(":      return K_LPAREN;
                ")":      return K_RPAREN;
                "*":      return K_STAR;
                "+":      return K_PLUS;
                "-":      return K_MINUS;
                CH_DOT:   return K_DOT;
                ":":      return K_COLON;
                ";":      return K_SEMI;
                "<":      return K_LT;
                "=":      return K_EQ;
                ">":      return K_GT;
                "{":      return K_LBRACE;
                "}":      return K_RBRACE;
                default:  return K_INVALID;
            endcase
        endfunction

        // Keyword when the length and the stored leading characters both match.
        function kind_t name_kind();
            logic [KW_BITS-1:0] packed_kw;
            for (int k = 0; k < KW_COUNT; k++) begin
                packed_kw = '0;
                for (int i = 0; i < kw_names[k].len(); i++)
                    packed_kw[8*i +: 8] = kw_names[k][i];
                if (tok_len == FIELD_W'(kw_names[k].len()) && prefix == packed_kw)
                    return kind_t'(K_KW_FN + k);
            end
            return K_IDENT;
        endfunction

        function void emit(kind_t kind, logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] len,
                           logic err);
            out_t tok;
            tok.token_kind = kind;
            tok.start_offset = start;
            tok.token_length = len;
            tok.is_error = err;
            tok.last_of_run = 1'b0;
            expected_tokens = {expected_tokens, tok};
        endfunction

        function void start_token(lex_mode_e m, logic [7:0] b);
            mode = m;
            tok_start = position;
            tok_len = FIELD_W'(1);
            prefix = (m == LX_IDENT) ? KW_BITS'(b) : '0;
        endfunction

        function void extend(logic [7:0] b);
            if (mode == LX_IDENT && tok_len < KW_CHARS)
                prefix[8*tok_len +: 8] = b;
            tok_len = bump(tok_len);
        endfunction

        function void close_pending();
            case (mode)
                LX_IDENT:          emit(name_kind(), tok_start, tok_len, 1'b0);
                LX_INT, LX_FRAC:   emit(K_NUMBER, tok_start, tok_len, 1'b0);
                LX_SLASH:          emit(K_SLASH, tok_start, FIELD_W'(1), 1'b0);
                LX_AMP:            emit(K_AMP, tok_start, FIELD_W'(1), 1'b0);
                LX_COMMENT:
                begin
                    if (comments_on)
                        emit(K_COMMENT, tok_start, tok_len, 1'b0);
                end
                default: ;
            endcase
            mode = LX_IDLE;
        endfunction

        // One accepted byte: queue every token it completes.
        function void lex_byte(logic [7:0] b, logic eot);
            int    n_before;
            bit    used;
            kind_t k;
            n_before = expected_tokens.size();
            used = 1'b0;
            case (mode)
                LX_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b)) begin extend(b); used = 1'b1; end
                end
                LX_INT:
                begin
                    if (is_digit(b)) begin
                        extend(b);
                        used = 1'b1;
                    end else if (b == CH_DOT) begin
                        extend(b);
                        mode = LX_FRAC;
                        used = 1'b1;
                    end
                end
                LX_FRAC:
                begin
                    if (is_digit(b)) begin extend(b); used = 1'b1; end
                end
                LX_SLASH:
                begin
                    if (b == CH_SLASH) begin
                        mode = LX_COMMENT;
                        extend(b);
                        used = 1'b1;
                    end
                end
                LX_AMP:
                begin
                    if (b == CH_AMP) begin
                        emit(K_AMPAMP, tok_start, FIELD_W'(2), 1'b0);
                        mode = LX_IDLE;
                        used = 1'b1;
                    end
                end
                LX_COMMENT:
                begin
                    // the line feed ends the comment but is not part of it
                    if (b == CH_LF)
                        close_pending();
                    else
                        extend(b);
                    used = 1'b1;
                end
                default: ;
            endcase

            if (!used) begin
                close_pending();
                if (!is_white(b)) begin
                    if (is_alpha(b))
                        start_token(LX_IDENT, b);
                    else if (is_digit(b))
                        start_token(LX_INT, b);
                    else if (b == CH_SLASH)
                        start_token(LX_SLASH, b);
                    else if (b == CH_AMP)
                        start_token(LX_AMP, b);
                    else begin
                        k = single_kind(b);
                        emit(k, position, FIELD_W'(1), k == K_INVALID);
                    end
                end
            end

            position = bump(position);

            if (eot) begin
                close_pending();
                restart();
            end

            if (expected_tokens.size() > n_before)
                expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
        endfunction

        function void report(string field, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_token(out_t got);
            out_t want;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none got kind %0d start %0d len %0d",
                         $time, got.token_kind, got.start_offset, got.token_length);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report("token_kind", FIELD_W'(want.token_kind), FIELD_W'(got.token_kind));
            if (got.start_offset !== want.start_offset)
                report("start_offset", want.start_offset, got.start_offset);
            if (got.token_length !== want.token_length)
                report("token_length", want.token_length, got.token_length);
            if (got.is_error !== want.is_error)
                report("is_error", FIELD_W'(want.is_error), FIELD_W'(got.is_error));
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", FIELD_W'(want.last_of_run), FIELD_W'(got.last_of_run));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    token_tracker tracker;
    logic [7:0]   text_q[$];
    bit           no_idle;
    bit           hold_output;

    source_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #800000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_comments(input logic en);
        cfg_data <= en;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.comments_on = en;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= '{b, eot};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.lex_byte(b, eot);
    endtask

    // Wait for the owed tokens, bounded, then let the pipeline drain.
    task automatic settle();
        int waited;
        for (waited = 0; tracker.expected_tokens.size() != 0 && waited < 2000; waited++)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send text_q, end of text on the last byte and, if asked, now and then mid-text.
    task automatic run_text(input bit breaks);
        logic eot;
        for (int i = 0; i < text_q.size(); i++) begin
            eot = (i == text_q.size() - 1) || (breaks && $urandom_range(39) == 0);
            send_byte(text_q[i], eot);
        end
        in_valid <= 1'b0;
        settle();
    endtask

    task automatic put_byte(input logic [7:0] c);
        text_q = {text_q, c};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? 8'h61 : 8'h41;  // lower or upper case
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    task automatic add_token();
        string      punct;
        string      blanks;
        string      w;
        int         pick;
        logic [7:0] c;
        punct = "/()*+-.:;<=>{}";
        blanks = " \t\n\r";
        pick = $urandom_range(99);
        if (pick < 18)
            add_text(tracker.kw_names[$urandom_range(KW_COUNT - 1)]);
        else if (pick < 34) begin
            // cut, whole or extended keywords next to plain names
            if ($urandom_range(2) == 0) begin
                w = tracker.kw_names[$urandom_range(KW_COUNT - 1)];
                add_text(w.substr(0, $urandom_range(w.len() - 1)));
            end else
                put_byte(rand_letter());
            repeat ($urandom_range(8))
                put_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter());
        end else if (pick < 48) begin
            repeat ($urandom_range(4, 1)) put_byte(rand_digit());
            if ($urandom_range(1)) begin
                put_byte(CH_DOT);
                repeat ($urandom_range(3)) put_byte(rand_digit());
            end
        end else if (pick < 56) begin
            add_text("//");
            repeat ($urandom_range(12)) begin
                c = 8'($urandom_range(255));
                put_byte(c == CH_LF ? CH_SPACE : c);
            end
            if ($urandom_range(5) != 0)
                put_byte(CH_LF);
        end else if (pick < 62)
            add_text("&&");
        else if (pick < 66)
            put_byte(CH_AMP);
        else if (pick < 84)
            put_byte(punct[$urandom_range(13)]);
        else if (pick < 92)
            put_byte(8'($urandom_range(255)));
        else
            put_byte(blanks[$urandom_range(3)]);
        if ($urandom_range(1))
            put_byte(blanks[$urandom_range(3)]);
    endtask

    initial
    begin : output_side
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_output) begin
                // long back-pressure so the token queue fills and in_ready drops
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end else begin
                gap = no_idle ? 0 : $urandom_range(3);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            tracker.check_token(out_data);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keyword, number with fraction, ampamp, name closed by an invalid byte,
        // byte extremes, comment running into end of text
        write_comments(1'b1);
        text_q.delete();
        add_text("while 7.5&&x");
        put_byte(8'hFF);
        put_byte(8'h00);
        add_text("//z");
        run_text(1'b0);

        // lone amp and lone slash at end of text
        text_q.delete();
        put_byte(CH_AMP);
        run_text(1'b0);
        text_q.delete();
        put_byte(CH_SLASH);
        run_text(1'b0);

        // dropped comment, number ending in a dot at end of text
        write_comments(1'b0);
        text_q.delete();
        add_text("//q\n4.");
        run_text(1'b0);

        for (int p = 0; p < 10; p++) begin
            write_comments(p < 6 ? p[0] : 1'($urandom_range(1)));
            no_idle = (p == 5 || p == 6);
            hold_output = (p == 3);
            text_q.delete();
            while (text_q.size() < 48) add_token();
            run_text(1'b1);
        end

        if (tracker.expected_tokens.size() != 0)
            $display("%0t: %0d expected tokens never arrived", $time,
                     tracker.expected_tokens.size());
        if (tracker.mismatches == 0 && tracker.expected_tokens.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
